>>> rtl/core/iso_packet_pacer_ring_reader_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the isochronous packet pacer
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef ISO_PACKET_PACER_RING_READER_MACROS_SVH
`define ISO_PACKET_PACER_RING_READER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ippr_pkg.sv
// ----------------------------------------------------------------------------
// ippr_pkg
// Types, codes, limits and the control store of the isochronous packet pacer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ippr_pkg;

    // Default limits on the packet base size and the ring size.
    localparam int unsigned DEF_MAX_BUFFER_BYTES = 65536;
    localparam int unsigned DEF_MAX_PACKET_BYTES = 1024;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int LEN_W    = 11;
    localparam int RES_W    = 13;
    localparam int IVL_W    = 13;
    localparam int FRM_W    = 6;
    localparam int SIZE_W   = 17;
    localparam int POS_W    = 16;
    localparam int ACC_W    = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;
    localparam int STEP_W   = 4;
    localparam int MOD_CNT_W = 5;

    // Stream commands.
    localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OTHER  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESIDUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER   = 3'd6;

    // Datapath operation of one microcode step.
    typedef enum logic [3:0] {
        OP_WAIT,
        OP_NOP,
        OP_MUL,
        OP_LEN,
        OP_MOD_PER_LOAD,
        OP_MOD_STEP,
        OP_ELAPSED,
        OP_MOD_BUF_LOAD,
        OP_PACKET,
        OP_TRIG,
        OP_DROP,
        OP_INACT,
        OP_EMIT
    } t_uop;

    // Jump condition of one microcode step; when true the step counter
    // loads the target, otherwise it advances by one.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_TRIGGER,
        C_DROP,
        C_INACTIVE,
        C_MOD_BUSY,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop              op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // One result word.
    typedef struct packed {
        logic             trigger_error;
        logic [POS_W-1:0] position_bytes;
        logic             period_elapsed;
        logic [LEN_W-1:0] first_chunk_bytes;
        logic [POS_W-1:0] read_offset;
        logic             copy_valid;
        logic [LEN_W-1:0] packet_bytes;
        logic             requeue;
    } t_result;

    // Program addresses.
    localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MUL      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CHK_DROP = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CHK_ACT  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LEN      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PER_LOAD = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PER_LOOP = 4'd6;
    localparam logic [STEP_W-1:0] STEP_ELAPSED  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_BUF_LOAD = 4'd8;
    localparam logic [STEP_W-1:0] STEP_BUF_LOOP = 4'd9;
    localparam logic [STEP_W-1:0] STEP_PACKET   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_TRIG     = 4'd11;
    localparam logic [STEP_W-1:0] STEP_DROP     = 4'd12;
    localparam logic [STEP_W-1:0] STEP_INACT    = 4'd13;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd14;
    localparam logic [STEP_W-1:0] STEP_RETURN   = 4'd15;

    // Control store: one control word per program step.
    function automatic t_ctrl ippr_rom(input logic [STEP_W-1:0] step);
        t_ctrl w;
        begin
            case (step)
                STEP_WAIT:     w = '{OP_WAIT,         C_NO_INPUT, STEP_WAIT};
                STEP_MUL:      w = '{OP_MUL,          C_TRIGGER,  STEP_TRIG};
                STEP_CHK_DROP: w = '{OP_NOP,          C_DROP,     STEP_DROP};
                STEP_CHK_ACT:  w = '{OP_NOP,          C_INACTIVE, STEP_INACT};
                STEP_LEN:      w = '{OP_LEN,          C_NEVER,    STEP_WAIT};
                STEP_PER_LOAD: w = '{OP_MOD_PER_LOAD, C_NEVER,    STEP_WAIT};
                STEP_PER_LOOP: w = '{OP_MOD_STEP,     C_MOD_BUSY, STEP_PER_LOOP};
                STEP_ELAPSED:  w = '{OP_ELAPSED,      C_NEVER,    STEP_WAIT};
                STEP_BUF_LOAD: w = '{OP_MOD_BUF_LOAD, C_NEVER,    STEP_WAIT};
                STEP_BUF_LOOP: w = '{OP_MOD_STEP,     C_MOD_BUSY, STEP_BUF_LOOP};
                STEP_PACKET:   w = '{OP_PACKET,       C_ALWAYS,   STEP_EMIT};
                STEP_TRIG:     w = '{OP_TRIG,         C_ALWAYS,   STEP_EMIT};
                STEP_DROP:     w = '{OP_DROP,         C_ALWAYS,   STEP_EMIT};
                STEP_INACT:    w = '{OP_INACT,        C_NEVER,    STEP_WAIT};
                STEP_EMIT:     w = '{OP_EMIT,         C_OUT_BUSY, STEP_EMIT};
                STEP_RETURN:   w = '{OP_NOP,          C_ALWAYS,   STEP_WAIT};
                default:       w = '{OP_NOP,          C_ALWAYS,   STEP_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/iso_packet_pacer_ring_reader.sv
// ----------------------------------------------------------------------------
// iso_packet_pacer_ring_reader
// Paces isochronous audio IN packets and tracks the ring buffer read position.
// ----------------------------------------------------------------------------
// Each input word is a stream command. A packet-done word, with the endpoint
// enabled, no shutdown and the stream active, runs the full program: the
// length is formed from a registered frame-times-interval product, and two
// 17-step shift-subtract remainder loops on one shared unit give the period
// offset and the wrapped position. Start, stop, unknown triggers, dropped
// packets and requeues on an inactive stream take shorter paths through the
// program. The control is a 16-step microprogram; one word is accepted at a
// time, and the next word is taken once the sequencer has passed its return
// step and is back at the wait step after the previous result enters the
// output register, even while that result still waits there. A result
// that cannot enter a full output register holds the sequencer and stalls
// the input. Configuration writes are accepted in any cycle and take effect
// at once.
`timescale 1ns / 1ps
`default_nettype none

`include "iso_packet_pacer_ring_reader_macros.svh"

module iso_packet_pacer_ring_reader
    import ippr_pkg::*;
#(
    parameter int unsigned MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES,
    parameter int unsigned MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Configuration writes.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,

    // Command words.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,  // [1:0] command
    input  wire logic                 s_axis_tuser,  // [0] shutdown

    // Result words.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [0] requeue, [11:1] packet_bytes, [12] copy_valid, [28:13] read_offset,
    // [39:29] first_chunk_bytes, [40] period_elapsed, [56:41] position_bytes,
    // [57] trigger_error
    output logic [63:0]               m_axis_tdata
);

    // Configuration registers.
    logic             r_cfg_enable;
    logic [LEN_W-1:0] r_cfg_base;
    logic [RES_W-1:0] r_cfg_residue;
    logic [IVL_W-1:0] r_cfg_ivl;
    logic [FRM_W-1:0] r_cfg_frame;
    logic [SIZE_W-1:0] r_cfg_period;
    logic [SIZE_W-1:0] r_cfg_buffer;

    // Stream state.
    logic             r_active;
    logic [POS_W-1:0] r_pos;
    logic [ACC_W-1:0] r_accum;
    logic [LEN_W-1:0] r_last;

    // Sequencer and datapath registers.
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic [CMD_W-1:0]  r_cmd;
    logic              r_shut;
    logic [ACC_W-1:0]  r_sum;
    logic [ACC_W-1:0]  r_thresh;
    logic [LEN_W-1:0]  r_len;
    logic              r_elapsed;
    t_result           r_res;

    // Shared remainder unit.
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W-1:0]    r_dvd;
    logic [SIZE_W-1:0]    r_div;
    logic [MOD_CNT_W-1:0] r_cnt;

    // Output register.
    logic    r_out_valid;
    t_result r_out;

    logic in_accept;
    logic cfg_accept;
    logic out_free;

    assign ctrl          = ippr_rom(r_step);
    assign s_axis_tready = (ctrl.op == OP_WAIT);
    assign o_cfg_ready   = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_accept    = i_cfg_valid && o_cfg_ready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Effective sizes: a zero interval, period or buffer reads as one, and the limits clamp.
    logic [IVL_W-1:0]  ivl_eff;
    logic [SIZE_W-1:0] per_eff;
    logic [SIZE_W-1:0] buf_eff;
    logic [LEN_W-1:0]  base_eff;

    always_comb begin
        ivl_eff = (r_cfg_ivl == '0) ? IVL_W'(1) : r_cfg_ivl;
        per_eff = (r_cfg_period == '0) ? SIZE_W'(1) : r_cfg_period;
        buf_eff = (r_cfg_buffer == '0) ? SIZE_W'(1) : r_cfg_buffer;
        if (32'(buf_eff) > MAX_BUFFER_BYTES) begin
            buf_eff = SIZE_W'(MAX_BUFFER_BYTES);
        end
        base_eff = r_cfg_base;
        if (32'(r_cfg_base) > MAX_PACKET_BYTES) begin
            base_eff = LEN_W'(MAX_PACKET_BYTES);
        end
    end

    // Packet length: one extra frame when the accumulator reaches the threshold.
    logic             frame_hit;
    logic [LEN_W:0]   len_sum;
    logic [LEN_W-1:0] len_sat;

    always_comb begin
        frame_hit = (r_sum >= r_thresh);
        len_sum   = {1'b0, base_eff} + (frame_hit ? (LEN_W + 1)'(r_cfg_frame) : '0);
        len_sat   = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
    end

    // One restoring step of the remainder unit.
    logic [SIZE_W:0]   rem_shift;
    logic [SIZE_W:0]   rem_sub;
    logic [SIZE_W-1:0] rem_next;

    always_comb begin
        rem_shift = {r_rem, r_dvd[SIZE_W-1]};
        rem_sub   = rem_shift - {1'b0, r_div};
        rem_next  = (rem_shift >= {1'b0, r_div}) ? rem_sub[SIZE_W-1:0]
                                                 : rem_shift[SIZE_W-1:0];
    end

    // Period check, wrap sum and bytes left before the ring end.
    logic              period_hit;
    logic [SIZE_W-1:0] pos_len;
    logic [SIZE_W-1:0] buf_left;
    logic              wraps;

    always_comb begin
        period_hit = ({1'b0, r_rem} + (SIZE_W + 1)'(r_len)) >= {1'b0, per_eff};
        pos_len    = {1'b0, r_pos} + SIZE_W'(r_len);
        buf_left   = buf_eff - {1'b0, r_pos};
        wraps      = ({1'b0, r_pos} < buf_eff) && (buf_left < SIZE_W'(r_len));
    end

    // Step counter with conditional jumps.
    logic jump;

    always_comb begin
        case (ctrl.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !in_accept;
            C_TRIGGER:  jump = (r_cmd != CMD_PACKET);
            C_DROP:     jump = !r_cfg_enable || r_shut;
            C_INACTIVE: jump = !r_active;
            C_MOD_BUSY: jump = (r_cnt != '0);
            C_OUT_BUSY: jump = !out_free;
            default:    jump = 1'b0;
        endcase
        n_step = jump ? ctrl.target : r_step + STEP_W'(1);
    end

    // Sequencer, datapath, configuration and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= STEP_WAIT;
            r_out_valid   <= 1'b0;
            r_active      <= 1'b0;
            r_pos         <= '0;
            r_accum       <= '0;
            r_last        <= '0;
            r_cfg_enable  <= 1'b0;
            r_cfg_base    <= '0;
            r_cfg_residue <= '0;
            r_cfg_ivl     <= IVL_W'(1000);
            r_cfg_frame   <= FRM_W'(4);
            r_cfg_period  <= SIZE_W'(4096);
            r_cfg_buffer  <= SIZE_W'(24576);
        end else begin
            r_step <= n_step;

            // Result handoff to the output register.
            if (ctrl.op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (ctrl.op)
                OP_WAIT: begin
                    r_cmd  <= s_axis_tdata[CMD_W-1:0];
                    r_shut <= s_axis_tuser;
                end
                OP_MUL: begin
                    r_sum    <= r_accum + ACC_W'(r_cfg_residue);
                    r_thresh <= ACC_W'(r_cfg_frame) * ACC_W'(ivl_eff);
                end
                OP_LEN: begin
                    r_len   <= len_sat;
                    r_last  <= len_sat;
                    r_accum <= frame_hit ? (r_sum - r_thresh) : r_sum;
                end
                OP_MOD_PER_LOAD: begin
                    r_rem <= '0;
                    r_dvd <= {1'b0, r_pos};
                    r_div <= per_eff;
                    r_cnt <= MOD_CNT_W'(SIZE_W - 1);
                end
                OP_MOD_BUF_LOAD: begin
                    r_rem <= '0;
                    r_dvd <= pos_len;
                    r_div <= buf_eff;
                    r_cnt <= MOD_CNT_W'(SIZE_W - 1);
                end
                OP_MOD_STEP: begin
                    r_rem <= rem_next;
                    r_dvd <= {r_dvd[SIZE_W-2:0], 1'b0};
                    r_cnt <= r_cnt - MOD_CNT_W'(1);
                end
                OP_ELAPSED: begin
                    r_elapsed <= period_hit;
                end
                OP_PACKET: begin
                    r_pos                   <= r_rem[POS_W-1:0];
                    r_res.requeue           <= 1'b1;
                    r_res.packet_bytes      <= r_len;
                    r_res.copy_valid        <= 1'b1;
                    r_res.read_offset       <= r_pos;
                    r_res.first_chunk_bytes <= wraps ? buf_left[LEN_W-1:0] : r_len;
                    r_res.period_elapsed    <= r_elapsed;
                    r_res.position_bytes    <= r_rem[POS_W-1:0];
                    r_res.trigger_error     <= 1'b0;
                end
                OP_TRIG: begin
                    r_pos <= '0;
                    if (r_cmd == CMD_START) begin
                        r_active <= 1'b1;
                    end else if (r_cmd == CMD_STOP) begin
                        r_active <= 1'b0;
                    end
                    r_res.requeue           <= 1'b0;
                    r_res.packet_bytes      <= '0;
                    r_res.copy_valid        <= 1'b0;
                    r_res.read_offset       <= '0;
                    r_res.first_chunk_bytes <= '0;
                    r_res.period_elapsed    <= 1'b0;
                    r_res.position_bytes    <= '0;
                    r_res.trigger_error     <= (r_cmd == CMD_OTHER);
                end
                OP_DROP: begin
                    r_res.requeue           <= 1'b0;
                    r_res.packet_bytes      <= '0;
                    r_res.copy_valid        <= 1'b0;
                    r_res.read_offset       <= '0;
                    r_res.first_chunk_bytes <= '0;
                    r_res.period_elapsed    <= 1'b0;
                    r_res.position_bytes    <= r_pos;
                    r_res.trigger_error     <= 1'b0;
                end
                OP_INACT: begin
                    r_res.requeue           <= 1'b1;
                    r_res.packet_bytes      <= r_last;
                    r_res.copy_valid        <= 1'b0;
                    r_res.read_offset       <= '0;
                    r_res.first_chunk_bytes <= '0;
                    r_res.period_elapsed    <= 1'b0;
                    r_res.position_bytes    <= r_pos;
                    r_res.trigger_error     <= 1'b0;
                end
                default: begin
                end
            endcase

            // Configuration writes; indexes beyond the list are ignored.
            if (cfg_accept) begin
                case (i_cfg_index)
                    CFG_ENABLE:   r_cfg_enable  <= i_cfg_data[0];
                    CFG_BASE:     r_cfg_base    <= i_cfg_data[LEN_W-1:0];
                    CFG_RESIDUE:  r_cfg_residue <= i_cfg_data[RES_W-1:0];
                    CFG_INTERVAL: r_cfg_ivl     <= i_cfg_data[IVL_W-1:0];
                    CFG_FRAME:    r_cfg_frame   <= i_cfg_data[FRM_W-1:0];
                    CFG_PERIOD:   r_cfg_period  <= i_cfg_data[SIZE_W-1:0];
                    CFG_BUFFER:   r_cfg_buffer  <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.trigger_error, r_out.position_bytes,
                            r_out.period_elapsed, r_out.first_chunk_bytes,
                            r_out.read_offset, r_out.copy_valid,
                            r_out.packet_bytes, r_out.requeue};

    // The remainder unit never divides by zero once loaded.
    `IPPR_ASSERT_NEXT(a_div_nonzero, i_clk, i_rst_n,
        ctrl.op == OP_MOD_PER_LOAD || ctrl.op == OP_MOD_BUF_LOAD,
        r_div != '0, "remainder unit loaded with a zero divisor")

    // A finished remainder is below its divisor.
    `IPPR_ASSERT_NEXT(a_rem_bound, i_clk, i_rst_n,
        ctrl.op == OP_MOD_STEP && r_cnt == '0,
        r_rem < r_div, "remainder not reduced below divisor")

    // After a paced packet the position lies inside the ring.
    `IPPR_ASSERT_NEXT(a_pos_in_ring, i_clk, i_rst_n,
        ctrl.op == OP_PACKET,
        ({1'b0, r_pos} < buf_eff), "ring position beyond buffer end")

endmodule

`default_nettype wire
